// ===== rtl/scc_pkg.sv =====
// Shared types and constants for the stick channel conditioner.
// No dependencies; used by every module of the block.
package scc_pkg;

  // Field widths
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned OffsetBits    = 11;
  localparam int unsigned ValueBits     = 16;
  localparam int unsigned NumChannels   = 4;
  localparam int unsigned ChanIdxBits   = 2;

  // Channel value constants
  localparam logic [ValueBits-1:0] BaseValue = 16'd1000;
  localparam logic [ValueBits-1:0] MirrorSum = 16'd3000;
  localparam logic [ValueBits-1:0] HighLimit = 16'd1999;
  localparam logic [ValueBits-1:0] HighSub   = 16'd1005;
  localparam logic [ValueBits-1:0] LowLimit  = 16'd1010;
  localparam logic [ValueBits-1:0] LowSub    = 16'd2000;

  // Configuration register indexes, also the lane order
  typedef enum logic [ChanIdxBits-1:0] {
    CfgThrottle = 2'd0,
    CfgPitch    = 2'd1,
    CfgYaw      = 2'd2,
    CfgRoll     = 2'd3
  } cfg_idx_e;

  typedef logic [ValueBits-1:0]  value_t;
  typedef logic signed [OffsetBits-1:0] offset_t;

  // Lane results handed to the merging stage
  typedef struct packed {
    logic   take;
    value_t throttle;
    value_t pitch;
    value_t yaw;
    value_t roll;
  } lane_res_t;

endpackage

// ===== rtl/scc_lane.sv =====
// One channel lane: offset add, optional mirror with overrides, alpha-1/4 smoothing.
// Depends on scc_pkg.
module scc_lane #(
  parameter int unsigned SAMPLE_BITS = scc_pkg::SampleBitsDef,
  parameter bit          MIRROR      = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  scc_pkg::offset_t       offset_i,
  input  logic                   take_i,
  output scc_pkg::value_t        result_o
);

  localparam int unsigned VB = scc_pkg::ValueBits;

  scc_pkg::value_t raw;
  scc_pkg::value_t val;
  logic [VB+1:0]   sum;
  scc_pkg::value_t hist_q;
  scc_pkg::value_t hist_d;

  // Base plus quarter sample plus sign-extended offset, modulo 2^16
  assign raw = scc_pkg::BaseValue
             + {{(VB-SAMPLE_BITS+2){1'b0}}, sample_i[SAMPLE_BITS-1:2]}
             + {{(VB-scc_pkg::OffsetBits){offset_i[scc_pkg::OffsetBits-1]}}, offset_i};

  // Mirror about 1500 with out-of-range overrides
  generate
    if (MIRROR) begin : g_mirror
      always_comb begin
        if (raw > scc_pkg::HighLimit) begin
          val = scc_pkg::HighSub;
        end else if (raw < scc_pkg::LowLimit) begin
          val = scc_pkg::LowSub;
        end else begin
          val = scc_pkg::MirrorSum - raw;
        end
      end
    end else begin : g_direct
      assign val = raw;
    end
  endgenerate

  // out = floor((v + 3*hist) / 4)
  assign sum    = {2'b00, val} + {1'b0, hist_q, 1'b0} + {2'b00, hist_q};
  assign hist_d = sum[VB+1:2];
  assign result_o = hist_d;

  // Filter history advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (take_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

// ===== rtl/scc_merge.sv =====
// Merging stage: gathers the four lane results into one output register.
// Depends on scc_pkg.
module scc_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::lane_res_t lanes_i,
  input  logic               out_stall_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output scc_pkg::value_t    throttle_out_o,
  output scc_pkg::value_t    pitch_out_o,
  output scc_pkg::value_t    yaw_out_o,
  output scc_pkg::value_t    roll_out_o
);

  logic               valid_q;
  logic               valid_d;
  scc_pkg::lane_res_t res_q;

  // Slot stays full while the consumer stalls
  assign busy_o = valid_q & out_stall_i;

  always_comb begin
    if (lanes_i.take) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (lanes_i.take) begin
      res_q <= lanes_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign throttle_out_o = res_q.throttle;
  assign pitch_out_o    = res_q.pitch;
  assign yaw_out_o      = res_q.yaw;
  assign roll_out_o     = res_q.roll;

endmodule

// ===== rtl/stick_channel_conditioner_top.sv =====
// Stick channel conditioner: four parallel channel lanes and an output register.
// A result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle unless the output slot is full and stalled.
// Reset: filter histories and offsets clear to zero, output slot empties.
// Depends on scc_pkg, scc_lane, scc_merge.
module stick_channel_conditioner_top #(
  parameter int unsigned SAMPLE_BITS = scc_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [scc_pkg::ChanIdxBits-1:0] cfg_idx_i,
  input  logic [scc_pkg::OffsetBits-1:0]  cfg_data_i,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          adc_throttle_i,
  input  logic [SAMPLE_BITS-1:0]          adc_pitch_i,
  input  logic [SAMPLE_BITS-1:0]          adc_yaw_i,
  input  logic [SAMPLE_BITS-1:0]          adc_roll_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scc_pkg::ValueBits-1:0]   throttle_out_o,
  output logic [scc_pkg::ValueBits-1:0]   pitch_out_o,
  output logic [scc_pkg::ValueBits-1:0]   yaw_out_o,
  output logic [scc_pkg::ValueBits-1:0]   roll_out_o
);

  scc_pkg::offset_t   throttle_off_q, pitch_off_q, yaw_off_q, roll_off_q;
  scc_pkg::lane_res_t lanes;
  logic               take;
  logic               busy;

  // Calibration offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_off_q <= '0;
      pitch_off_q    <= '0;
      yaw_off_q      <= '0;
      roll_off_q     <= '0;
    end else if (cfg_we_i) begin
      case (scc_pkg::cfg_idx_e'(cfg_idx_i))
        scc_pkg::CfgThrottle: throttle_off_q <= cfg_data_i;
        scc_pkg::CfgPitch:    pitch_off_q    <= cfg_data_i;
        scc_pkg::CfgYaw:      yaw_off_q      <= cfg_data_i;
        scc_pkg::CfgRoll:     roll_off_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input transfer
  assign in_stall_o = busy;
  assign take       = in_valid_i & ~busy;
  assign lanes.take = take;

  scc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MIRROR(1'b0)) u_lane_throttle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (adc_throttle_i),
    .offset_i (throttle_off_q),
    .take_i   (take),
    .result_o (lanes.throttle)
  );

  scc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MIRROR(1'b0)) u_lane_pitch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (adc_pitch_i),
    .offset_i (pitch_off_q),
    .take_i   (take),
    .result_o (lanes.pitch)
  );

  scc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MIRROR(1'b1)) u_lane_yaw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (adc_yaw_i),
    .offset_i (yaw_off_q),
    .take_i   (take),
    .result_o (lanes.yaw)
  );

  scc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MIRROR(1'b1)) u_lane_roll (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (adc_roll_i),
    .offset_i (roll_off_q),
    .take_i   (take),
    .result_o (lanes.roll)
  );

  scc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lanes_i        (lanes),
    .out_stall_i    (out_stall_i),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .throttle_out_o (throttle_out_o),
    .pitch_out_o    (pitch_out_o),
    .yaw_out_o      (yaw_out_o),
    .roll_out_o     (roll_out_o)
  );

endmodule

// ===== dv/stick_channel_conditioner_top_test.sv =====
// Self-checking testbench for stick_channel_conditioner_top: directed and random stick samples,
// each result checked against a cycle-free model of offset, mirror and smoothing, or a preset.
// Depends on scc_pkg and the stick_channel_conditioner_top RTL.
module stick_channel_conditioner_top_test;

  localparam int unsigned SampleBits = scc_pkg::SampleBitsDef;

  typedef logic [scc_pkg::NumChannels-1:0][SampleBits-1:0] sample_set_t;
  typedef scc_pkg::offset_t [scc_pkg::NumChannels-1:0] trim_set_t;
  typedef scc_pkg::value_t [scc_pkg::NumChannels-1:0] cmd_quad_t;

  // One step of the directed plan: either an offset load or a sample transfer
  typedef struct packed {
    logic        wr;
    logic        chk;
    trim_set_t   trims;
    sample_set_t smp;
    cmd_quad_t   cmd;
  } plan_row_t;

  // Fixed expectation attached to an item, if any
  typedef struct packed {
    logic      chk;
    cmd_quad_t cmd;
  } cmd_note_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [scc_pkg::ChanIdxBits-1:0] cfg_idx_i;
  logic [scc_pkg::OffsetBits-1:0]  cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [SampleBits-1:0]           adc_throttle_i;
  logic [SampleBits-1:0]           adc_pitch_i;
  logic [SampleBits-1:0]           adc_yaw_i;
  logic [SampleBits-1:0]           adc_roll_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [scc_pkg::ValueBits-1:0]   throttle_out_o;
  logic [scc_pkg::ValueBits-1:0]   pitch_out_o;
  logic [scc_pkg::ValueBits-1:0]   yaw_out_o;
  logic [scc_pkg::ValueBits-1:0]   roll_out_o;

  // Model state: loaded offsets and filter histories
  trim_set_t   trim_off = '0;
  cmd_quad_t   ema_hist = '0;
  cmd_quad_t   pending_cmds [$];
  cmd_note_t   preset_cmds [$];
  int unsigned mismatches = 0;
  bit          rx_quiet = 1'b0;
  bit          rx_hold_req = 1'b0;
  string       chan_name [scc_pkg::NumChannels] =
                 '{"throttle_out", "pitch_out", "yaw_out", "roll_out"};
  plan_row_t   plan [22];

  stick_channel_conditioner_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .adc_throttle_i (adc_throttle_i),
    .adc_pitch_i    (adc_pitch_i),
    .adc_yaw_i      (adc_yaw_i),
    .adc_roll_i     (adc_roll_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .throttle_out_o (throttle_out_o),
    .pitch_out_o    (pitch_out_o),
    .yaw_out_o      (yaw_out_o),
    .roll_out_o     (roll_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offset, mirror for yaw and roll, then alpha-quarter smoothing; advances the histories
  function automatic cmd_quad_t condition_sticks(sample_set_t smp);
    cmd_quad_t           cmd;
    scc_pkg::value_t     lvl;
    scc_pkg::cfg_idx_e   ch;
    ch = ch.first();
    do begin
      lvl = scc_pkg::BaseValue + scc_pkg::value_t'(smp[ch] >> 2)
          + {{(scc_pkg::ValueBits-scc_pkg::OffsetBits){trim_off[ch][scc_pkg::OffsetBits-1]}},
             trim_off[ch]};
      if (ch == scc_pkg::CfgYaw || ch == scc_pkg::CfgRoll) begin
        if (lvl > scc_pkg::HighLimit) lvl = scc_pkg::HighSub;
        else if (lvl < scc_pkg::LowLimit) lvl = scc_pkg::LowSub;
        else lvl = scc_pkg::MirrorSum - lvl;
      end
      cmd[ch] = scc_pkg::value_t'((32'(lvl) + 32'(ema_hist[ch]) * 3) >> 2);
      ema_hist[ch] = cmd[ch];
      ch = ch.next();
    end while (ch != ch.first());
    return cmd;
  endfunction

  function automatic plan_row_t step_row(int t, int p, int y, int r);
    plan_row_t row;
    row = '0;
    row.smp = {SampleBits'(r), SampleBits'(y), SampleBits'(p), SampleBits'(t)};
    return row;
  endfunction

  function automatic plan_row_t check_row(int t, int p, int y, int r,
                                          int et, int ep, int ey, int er);
    plan_row_t row;
    row = step_row(t, p, y, r);
    row.chk = 1'b1;
    row.cmd = {scc_pkg::value_t'(er), scc_pkg::value_t'(ey),
               scc_pkg::value_t'(ep), scc_pkg::value_t'(et)};
    return row;
  endfunction

  function automatic plan_row_t trim_row(int t, int p, int y, int r);
    plan_row_t row;
    row = '0;
    row.wr = 1'b1;
    row.trims = {scc_pkg::offset_t'(r), scc_pkg::offset_t'(y),
                 scc_pkg::offset_t'(p), scc_pkg::offset_t'(t)};
    return row;
  endfunction

  // Mostly zero, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic scc_pkg::offset_t pick_trim();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? scc_pkg::offset_t'(-1024) : scc_pkg::offset_t'(1023);
      1: return scc_pkg::offset_t'(int'($urandom_range(0, 100)) - 50);
      default: return scc_pkg::offset_t'($urandom_range(0, 2047));
    endcase
  endfunction

  // Uniform, near the range ends, or aimed at an override edge or the mirror center
  function automatic logic [SampleBits-1:0] pick_sample(scc_pkg::offset_t off);
    int marks [7] = '{1009, 1010, 1499, 1500, 1501, 1999, 2000};
    int d;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 6) begin
      return $urandom_range(0, 1) ? SampleBits'($urandom_range(0, 7))
                                  : SampleBits'((1 << SampleBits) - 1 - $urandom_range(0, 7));
    end
    if (r >= 7) begin
      d = marks[$urandom_range(0, 6)] - int'(scc_pkg::BaseValue) - int'(off);
      if (d >= 0 && d < (1 << (SampleBits - 2)))
        return SampleBits'(d * 4 + int'($urandom_range(0, 3)));
    end
    return SampleBits'($urandom_range(0, (1 << SampleBits) - 1));
  endfunction

  // Present one sample set and hold it until the transfer, then maybe idle
  task automatic offer_item(sample_set_t smp, logic chk, cmd_quad_t cmd, bit paced);
    cmd_note_t   note;
    int unsigned gap;
    note.chk = chk;
    note.cmd = cmd;
    preset_cmds.push_back(note);
    in_valid_i     <= 1'b1;
    adc_throttle_i <= smp[scc_pkg::CfgThrottle];
    adc_pitch_i    <= smp[scc_pkg::CfgPitch];
    adc_yaw_i      <= smp[scc_pkg::CfgYaw];
    adc_roll_i     <= smp[scc_pkg::CfgRoll];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = paced ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected result has been seen
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0 || preset_cmds.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all four offsets on consecutive edges
  task automatic load_trims(trim_set_t trims);
    scc_pkg::cfg_idx_e idx;
    idx = idx.first();
    do begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= trims[idx];
      @(posedge clk_i);
      trim_off[idx] = trims[idx];
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
  endtask

  // Result check first, then prediction for a new input transfer at the same edge
  always @(posedge clk_i) begin
    cmd_quad_t got;
    cmd_quad_t want;
    cmd_note_t note;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {roll_out_o, yaw_out_o, pitch_out_o, throttle_out_o};
        if (pending_cmds.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          for (int c = 0; c < scc_pkg::NumChannels; c++) begin
            if (got[c] !== want[c]) begin
              $error("%s: expected %0d, got %0d", chan_name[c], want[c], got[c]);
              mismatches++;
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = condition_sticks({adc_roll_i, adc_yaw_i, adc_pitch_i, adc_throttle_i});
        note = preset_cmds.pop_front();
        if (note.chk) want = note.cmd;
        pending_cmds.push_back(want);
      end
    end
  end

  // Receiver: random stalls, quiet stretches and one long hold-off on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        n = 150;
        rx_hold_req = 1'b0;
      end else if (rx_quiet) begin
        n = 0;
      end else begin
        n = pick_gap();
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (rx_quiet ? 8 : $urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Run limit
  initial begin
    #16_000_000;
    $display("stick_channel_conditioner_top: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    sample_set_t smp;
    trim_set_t   trims;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = scc_pkg::CfgThrottle;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    adc_throttle_i = '0;
    adc_pitch_i    = '0;
    adc_yaw_i      = '0;
    adc_roll_i     = '0;

    plan = '{
      // zero samples from reset: yaw and roll take the low override
      check_row(0, 0, 0, 0, 250, 250, 500, 500),
      check_row(0, 0, 0, 0, 437, 437, 875, 875),
      step_row(4095, 4095, 4095, 4095),
      step_row(2000, 2000, 2000, 2000),  // mirror center
      step_row(3996, 3999, 3996, 3999),  // just below high override
      step_row(4000, 4000, 4000, 4000),  // high override
      step_row(36, 39, 36, 39),          // low override
      step_row(40, 43, 40, 43),          // just above low override
      step_row(2730, 1365, 2730, 1365),
      step_row(1365, 2730, 1365, 2730),
      trim_row(-1024, -1024, -1024, -1024),
      step_row(0, 0, 0, 0),              // sum wraps below zero
      step_row(4095, 4095, 4095, 4095),
      step_row(100, 100, 100, 100),
      trim_row(1023, 1023, 1023, 1023),
      step_row(0, 0, 0, 0),
      step_row(4095, 4095, 4095, 4095),
      trim_row(500, -500, -477, 477),
      step_row(0, 4095, 3908, 92),       // yaw and roll land on the center
      step_row(4095, 0, 4095, 0),
      step_row(1, 2, 3, 2),
      step_row(2048, 1024, 512, 256)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        settle();
        load_trims(plan[i].trims);
      end else begin
        offer_item(plan[i].smp, plan[i].chk, plan[i].cmd, 1'b1);
      end
    end

    // Random phases, each with its own offsets; phase 1 fills the block, phase 2 runs flat out
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      for (int c = 0; c < scc_pkg::NumChannels; c++) trims[c] = pick_trim();
      load_trims(trims);
      rx_quiet = (ph == 2);
      if (ph == 1) rx_hold_req = 1'b1;
      for (int n = 0; n < 212; n++) begin
        for (int c = 0; c < scc_pkg::NumChannels; c++) smp[c] = pick_sample(trims[c]);
        offer_item(smp, 1'b0, '0, !(ph == 2 || (ph == 1 && n < 100)));
        if ($urandom_range(0, 149) == 0) settle();
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stick_channel_conditioner_top: match");
    end else begin
      $display("stick_channel_conditioner_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/scc_pkg.sv
rtl/scc_lane.sv
rtl/scc_merge.sv
rtl/stick_channel_conditioner_top.sv
dv/stick_channel_conditioner_top_test.sv
